// ===== src/wbs_pkg.sv =====
// wbs_pkg: shared types, sizes and opcode classification for the block end scanner
`timescale 1ns / 1ps

package wbs_pkg;

  // scan sizes
  localparam int OFFSET_BITS   = 24;
  localparam int DEPTH_BITS    = 16;
  localparam int LEBS_BITS     = 33;
  localparam int ACC_BITS      = 32;
  localparam int FIXED_BITS    = 4;
  localparam int SHIFT_BITS    = 3;
  localparam int CODE_BITS     = 8;
  localparam int OUT_DATA_BITS = ((OFFSET_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = '1;

  // register indexes; the wide drop and select opcodes (0 and 1) take no
  // immediate, so writes to them change nothing and need no storage
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_GET = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_SET = 2'd3;

  localparam logic [CODE_BITS-1:0] WIDE_GET_RESET = 8'd202;
  localparam logic [CODE_BITS-1:0] WIDE_SET_RESET = 8'd203;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_LEB,
    PH_FIXED,
    PH_COUNT
  } phase_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_BLOCK,
    C_ELSE,
    C_END,
    C_LEB1,
    C_LEB2,
    C_TABLE,
    C_LEB_FIX,
    C_FIX1,
    C_FIX4,
    C_FIX8
  } op_class_t;

  typedef enum logic [1:0] {
    OUT_ELSE,
    OUT_END,
    OUT_NOT_FOUND,
    OUT_OVERFLOW
  } outcome_t;

  // standard opcode classes, by immediate layout
  function automatic op_class_t wbs_classify(input logic [CODE_BITS-1:0] op);
    op_class_t c;
    c = C_NONE;
    if (op >= 8'h02 && op <= 8'h04) c = C_BLOCK;
    else if (op == 8'h05) c = C_ELSE;
    else if (op == 8'h0B) c = C_END;
    else if (op == 8'h0C || op == 8'h0D) c = C_LEB1;
    else if (op == 8'h0E) c = C_TABLE;
    else if (op == 8'h10) c = C_LEB1;
    else if (op == 8'h11) c = C_LEB_FIX;
    else if (op >= 8'h20 && op <= 8'h26) c = C_LEB1;
    else if (op >= 8'h28 && op <= 8'h3E) c = C_LEB2;
    else if (op >= 8'h3F && op <= 8'h42) c = C_LEB1;
    else if (op == 8'h43) c = C_FIX4;
    else if (op == 8'h44) c = C_FIX8;
    else if (op == 8'hD0) c = C_FIX1;
    else if (op == 8'hD2) c = C_LEB1;
    return c;
  endfunction

endpackage

// ===== src/wasm_block_end_scanner.sv =====
// wasm_block_end_scanner: finds the else or end that closes a wasm block
`timescale 1ns / 1ps

// Takes one code byte per transfer, starting just after a block header, and
// reports the offset of the first else or end at nesting zero (tuser 0 or 1),
// not-found with offset zero when the byte marked tlast passes first (tuser 2),
// or nesting overflow at the offending block, loop or if (tuser 3). A byte with
// in_tuser set restarts the scan at offset zero, whatever the state; between
// scans, bytes without it are consumed and ignored. Each byte is decoded in the
// cycle it is taken: the classifier and the counter updates sit in front of the
// scan state registers, and a result goes into a one-deep output register.
// The block takes one byte per cycle; in_tready drops only while a result sits
// in the output register and out_tready is low. A result is registered, so it
// shows on out_tvalid in the cycle after its byte. Offsets saturate at 2^24-1.
// Registers 2 and 3 hold the wide global get/set opcodes (one LEB index each);
// they apply only to bytes that have no standard opcode class.
// Registers 0 and 1 (wide drop/select) are accepted and have no effect.

module wasm_block_end_scanner
  import wbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [CODE_BITS-1:0]     in_tdata,   // [7:0] code_byte
  input  logic                     in_tuser,   // [0] first_byte
  input  logic                     in_tlast,   // last_byte
  // result channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [23:0] match_offset
  output logic [1:0]               out_tuser,  // [1:0] outcome
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CODE_BITS-1:0]     cfg_wdata
);

  // configuration registers
  logic [CODE_BITS-1:0] wide_get_r;
  logic [CODE_BITS-1:0] wide_set_r;

  // scan state
  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;
  logic [FIXED_BITS-1:0]  fixed_r, fixed_nxt;
  logic [LEBS_BITS-1:0]   lebs_r, lebs_nxt;
  logic                   after_r, after_nxt;
  logic [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic [SHIFT_BITS-1:0]  shift_r, shift_nxt;
  logic                   finished_r;

  // output register
  logic                   out_valid_r;
  outcome_t               out_code_r;
  logic [OFFSET_BITS-1:0] out_off_r;

  // effective state for this byte (a first byte sees a cleared scan)
  phase_t                 cur_phase;
  logic [OFFSET_BITS-1:0] cur_off;
  logic [DEPTH_BITS-1:0]  cur_depth;
  logic [FIXED_BITS-1:0]  cur_fixed;
  logic [LEBS_BITS-1:0]   cur_lebs;
  logic                   cur_after;
  logic [ACC_BITS-1:0]    cur_acc;
  logic [SHIFT_BITS-1:0]  cur_shift;

  logic                   in_xfer;
  logic                   active;
  logic                   step;
  op_class_t              cls;
  logic                   leb_more;
  logic                   overflow;
  logic [LEBS_BITS-1:0]   lebs_dec;
  logic [FIXED_BITS-1:0]  fixed_dec;
  logic [ACC_BITS-1:0]    acc_upd;
  logic [SHIFT_BITS-1:0]  shift_upd;
  logic [CODE_BITS-2:0]   payload7;
  logic                   found;
  outcome_t               found_code;
  logic                   res_valid;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign active    = in_tuser || !finished_r;
  assign step      = in_xfer && active;

  assign cur_phase = in_tuser ? PH_OPCODE : phase_r;
  assign cur_off   = in_tuser ? '0 : off_r;
  assign cur_depth = in_tuser ? '0 : depth_r;
  assign cur_fixed = in_tuser ? '0 : fixed_r;
  assign cur_lebs  = in_tuser ? '0 : lebs_r;
  assign cur_after = in_tuser ? 1'b0 : after_r;
  assign cur_acc   = in_tuser ? '0 : acc_r;
  assign cur_shift = in_tuser ? '0 : shift_r;

  // continuation bit of a leb byte
  assign leb_more  = in_tdata[CODE_BITS-1];
  assign payload7  = in_tdata[CODE_BITS-2:0];
  assign overflow  = (cur_depth == DEPTH_MAX);
  assign lebs_dec  = (cur_lebs != '0) ? cur_lebs - LEBS_BITS'(1) : '0;
  assign fixed_dec = (cur_fixed != '0) ? cur_fixed - FIXED_BITS'(1) : '0;

  // wide global get/set only claim bytes with no standard immediate
  always_comb begin
    cls = wbs_classify(in_tdata);
    if (cls == C_NONE && (in_tdata == wide_get_r || in_tdata == wide_set_r)) begin
      cls = C_LEB1;
    end
  end

  // branch table count: seven bits per byte, bits past 32 dropped
  always_comb begin
    acc_upd = cur_acc;
    unique case (cur_shift)
      3'd0:    acc_upd = cur_acc | {25'b0, payload7};
      3'd1:    acc_upd = cur_acc | {18'b0, payload7, 7'b0};
      3'd2:    acc_upd = cur_acc | {11'b0, payload7, 14'b0};
      3'd3:    acc_upd = cur_acc | {4'b0, payload7, 21'b0};
      3'd4:    acc_upd = cur_acc | {payload7[3:0], 28'b0};
      default: acc_upd = cur_acc;
    endcase
    shift_upd = (cur_shift < SHIFT_BITS'(5)) ? cur_shift + SHIFT_BITS'(1) : cur_shift;
  end

  // next phase
  always_comb begin
    phase_nxt = cur_phase;
    unique case (cur_phase)
      PH_OPCODE: begin
        unique case (cls)
          C_BLOCK:                    phase_nxt = overflow ? PH_OPCODE : PH_LEB;
          C_LEB1, C_LEB2, C_LEB_FIX:  phase_nxt = PH_LEB;
          C_TABLE:                    phase_nxt = PH_COUNT;
          C_FIX1, C_FIX4, C_FIX8:     phase_nxt = PH_FIXED;
          default:                    phase_nxt = PH_OPCODE;
        endcase
      end
      PH_LEB: begin
        if (!leb_more && lebs_dec == '0) begin
          phase_nxt = cur_after ? PH_FIXED : PH_OPCODE;
        end
      end
      PH_FIXED: begin
        if (fixed_dec == '0) phase_nxt = PH_OPCODE;
      end
      PH_COUNT: begin
        if (!leb_more) phase_nxt = PH_LEB;
      end
    endcase
  end

  // counters and the match decision
  always_comb begin
    depth_nxt  = cur_depth;
    fixed_nxt  = cur_fixed;
    lebs_nxt   = cur_lebs;
    after_nxt  = cur_after;
    acc_nxt    = cur_acc;
    shift_nxt  = cur_shift;
    found      = 1'b0;
    found_code = OUT_END;
    unique case (cur_phase)
      PH_OPCODE: begin
        unique case (cls)
          C_BLOCK: begin
            if (overflow) begin
              found      = 1'b1;
              found_code = OUT_OVERFLOW;
            end else begin
              depth_nxt = cur_depth + DEPTH_BITS'(1);
              lebs_nxt  = LEBS_BITS'(1);
            end
          end
          C_ELSE: begin
            if (cur_depth == '0) begin
              found      = 1'b1;
              found_code = OUT_ELSE;
            end
          end
          C_END: begin
            if (cur_depth == '0) begin
              found      = 1'b1;
              found_code = OUT_END;
            end else begin
              depth_nxt = cur_depth - DEPTH_BITS'(1);
            end
          end
          C_LEB1: lebs_nxt = LEBS_BITS'(1);
          C_LEB2: lebs_nxt = LEBS_BITS'(2);
          C_LEB_FIX: begin
            lebs_nxt  = LEBS_BITS'(1);
            after_nxt = 1'b1;
          end
          C_TABLE: begin
            acc_nxt   = '0;
            shift_nxt = '0;
          end
          C_FIX1: fixed_nxt = FIXED_BITS'(1);
          C_FIX4: fixed_nxt = FIXED_BITS'(4);
          C_FIX8: fixed_nxt = FIXED_BITS'(8);
          default: ;
        endcase
      end
      PH_LEB: begin
        if (!leb_more) begin
          lebs_nxt = lebs_dec;
          // indirect call: table byte follows the type index
          if (lebs_dec == '0 && cur_after) begin
            after_nxt = 1'b0;
            fixed_nxt = FIXED_BITS'(1);
          end
        end
      end
      PH_FIXED: fixed_nxt = fixed_dec;
      PH_COUNT: begin
        acc_nxt   = acc_upd;
        shift_nxt = shift_upd;
        // targets plus the default target
        if (!leb_more) lebs_nxt = {1'b0, acc_upd} + LEBS_BITS'(1);
      end
    endcase
  end

  assign res_valid = found || in_tlast;
  assign off_nxt   = (cur_off == OFFSET_MAX) ? cur_off : cur_off + OFFSET_BITS'(1);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_get_r <= WIDE_GET_RESET;
      wide_set_r <= WIDE_SET_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDE_GET) wide_get_r <= cfg_wdata;
      if (cfg_index == CFG_WIDE_SET) wide_set_r <= cfg_wdata;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPCODE;
      off_r      <= '0;
      depth_r    <= '0;
      fixed_r    <= '0;
      lebs_r     <= '0;
      after_r    <= 1'b0;
      acc_r      <= '0;
      shift_r    <= '0;
      finished_r <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      off_r      <= off_nxt;
      depth_r    <= depth_nxt;
      fixed_r    <= fixed_nxt;
      lebs_r     <= lebs_nxt;
      after_r    <= after_nxt;
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      finished_r <= res_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_code_r <= found ? found_code : OUT_NOT_FOUND;
      out_off_r  <= found ? cur_off : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = OUT_DATA_BITS'(out_off_r);

  // a result only ever follows an input transfer
  a_result_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_xfer))
    else $error("result appeared without an input transfer");

  // any reported result closes the scan
  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid) |=> finished_r)
    else $error("scan still open after a result");

  // the leb phase always has at least one field left
  a_leb_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEB) |-> (lebs_r != '0))
    else $error("leb phase with no field left");

  // the fixed phase always has at least one byte left
  a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FIXED) |-> (fixed_r != '0))
    else $error("fixed phase with no byte left");

endmodule

// ===== test/wasm_block_end_scanner_tb.sv =====
// testbench for the wasm block end scanner: directed and random byte streams against a local scan tracker
`timescale 1ns / 1ps

module wasm_block_end_scanner_tb;
  import wbs_pkg::*;

  // register indexes not named in the package
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_DROP   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_SELECT = 2'd1;

  // opcodes and immediate bytes used by the stimulus
  localparam logic [7:0] OP_UNREACHABLE = 8'h00;
  localparam logic [7:0] OP_NOP         = 8'h01;
  localparam logic [7:0] OP_BLOCK       = 8'h02;
  localparam logic [7:0] OP_LOOP        = 8'h03;
  localparam logic [7:0] OP_IF          = 8'h04;
  localparam logic [7:0] OP_ELSE        = 8'h05;
  localparam logic [7:0] OP_END         = 8'h0B;
  localparam logic [7:0] OP_BR          = 8'h0C;
  localparam logic [7:0] OP_BR_IF       = 8'h0D;
  localparam logic [7:0] OP_BR_TBL      = 8'h0E;
  localparam logic [7:0] OP_CALL        = 8'h10;
  localparam logic [7:0] OP_CALL_IND    = 8'h11;
  localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
  localparam logic [7:0] OP_TABLE_SET   = 8'h26;
  localparam logic [7:0] OP_I32_LOAD    = 8'h28;
  localparam logic [7:0] OP_I64_STORE32 = 8'h3E;
  localparam logic [7:0] OP_MEM_SIZE    = 8'h3F;
  localparam logic [7:0] OP_I64_CONST   = 8'h42;
  localparam logic [7:0] OP_I32_CONST   = 8'h41;
  localparam logic [7:0] OP_F32_CONST   = 8'h43;
  localparam logic [7:0] OP_F64_CONST   = 8'h44;
  localparam logic [7:0] OP_REF_NULL    = 8'hD0;
  localparam logic [7:0] OP_REF_FUNC    = 8'hD2;
  localparam logic [7:0] BT_EMPTY       = 8'h40;
  localparam logic [7:0] BT_FIRST_VAL   = 8'h6F;
  localparam logic [7:0] BT_LAST_VAL    = 8'h7F;
  localparam logic [7:0] LEB_MORE       = 8'h80;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 4;     // pause after the last result before a register write
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int NEST_LEVELS  = 24;    // deep nesting, well past the random depth

  typedef struct packed {
    outcome_t                 kind;
    logic [OFFSET_BITS-1:0]   offset;
  } close_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [CODE_BITS-1:0]     in_tdata;   // [7:0] code_byte
  logic                     in_tuser;   // [0] first_byte
  logic                     in_tlast;   // last_byte
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // [23:0] match_offset
  logic [1:0]               out_tuser;  // [1:0] outcome
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CODE_BITS-1:0]     cfg_wdata;

  wasm_block_end_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // scan tracker state, starts as after reset: idle until a first byte
  logic [7:0]             wide_get_op    = WIDE_GET_RESET;
  logic [7:0]             wide_set_op    = WIDE_SET_RESET;
  logic [OFFSET_BITS-1:0] scan_offset    = '0;
  logic [DEPTH_BITS-1:0]  scan_depth     = '0;
  phase_t                 scan_phase     = PH_OPCODE;
  logic [FIXED_BITS-1:0]  fixed_left     = '0;
  logic [LEBS_BITS-1:0]   lebs_left      = '0;
  bit                     fixed_after    = 1'b0;
  logic [ACC_BITS-1:0]    count_acc      = '0;
  logic [SHIFT_BITS-1:0]  count_shift    = '0;
  bit                     scan_done      = 1'b1;

  close_t pending_closes[$];  // closing results still to come out of the block
  int     closes_predicted = 0;
  int     live_bytes       = 0;  // bytes that took part in a scan
  int     err_count        = 0;
  int     quiet_cycles     = 0;

  // idling controls shared between the sender, the receiver and the tests
  bit tx_idle_en     = 1'b1;
  bit rx_idle_en     = 1'b1;
  int rx_hold_cycles = 0;
  int rx_stall_left  = 0;

  // standard immediate layout of an opcode
  function automatic op_class_t opcode_kind(input logic [7:0] op);
    op_class_t k;
    k = C_NONE;
    if (op inside {[OP_BLOCK:OP_IF]}) k = C_BLOCK;
    else if (op == OP_ELSE) k = C_ELSE;
    else if (op == OP_END) k = C_END;
    else if (op == OP_BR_TBL) k = C_TABLE;
    else if (op == OP_CALL_IND) k = C_LEB_FIX;
    else if (op inside {[OP_I32_LOAD:OP_I64_STORE32]}) k = C_LEB2;
    else if (op inside {OP_BR, OP_BR_IF, OP_CALL, [OP_LOCAL_GET:OP_TABLE_SET],
                        [OP_MEM_SIZE:OP_I64_CONST], OP_REF_FUNC}) k = C_LEB1;
    else if (op == OP_F32_CONST) k = C_FIX4;
    else if (op == OP_F64_CONST) k = C_FIX8;
    else if (op == OP_REF_NULL) k = C_FIX1;
    return k;
  endfunction

  // wide global get/set only claim bytes with no standard immediate
  function automatic op_class_t effective_kind(input logic [7:0] op);
    op_class_t k;
    k = opcode_kind(op);
    if (k == C_NONE && (op == wide_get_op || op == wide_set_op)) k = C_LEB1;
    return k;
  endfunction

  // advance the scan by one accepted byte and queue the result it closes with
  function automatic void step_scan(input logic [7:0] code, input bit first, input bit last);
    bit       hit;
    outcome_t hit_kind;
    close_t   c;
    if (first) begin
      scan_offset = '0;
      scan_depth  = '0;
      scan_phase  = PH_OPCODE;
      fixed_left  = '0;
      lebs_left   = '0;
      fixed_after = 1'b0;
      count_acc   = '0;
      count_shift = '0;
      scan_done   = 1'b0;
    end else if (scan_done) begin
      return;
    end
    live_bytes++;
    hit      = 1'b0;
    hit_kind = OUT_ELSE;
    case (scan_phase)
      PH_OPCODE: begin
        case (effective_kind(code))
          C_BLOCK: begin
            if (scan_depth == DEPTH_MAX) begin
              hit      = 1'b1;
              hit_kind = OUT_OVERFLOW;
            end else begin
              scan_depth++;
              lebs_left  = LEBS_BITS'(1);
              scan_phase = PH_LEB;
            end
          end
          C_ELSE: begin
            if (scan_depth == '0) begin
              hit      = 1'b1;
              hit_kind = OUT_ELSE;
            end
          end
          C_END: begin
            if (scan_depth == '0) begin
              hit      = 1'b1;
              hit_kind = OUT_END;
            end else begin
              scan_depth--;
            end
          end
          C_LEB1: begin
            lebs_left  = LEBS_BITS'(1);
            scan_phase = PH_LEB;
          end
          C_LEB2: begin
            lebs_left  = LEBS_BITS'(2);
            scan_phase = PH_LEB;
          end
          C_LEB_FIX: begin
            lebs_left   = LEBS_BITS'(1);
            fixed_after = 1'b1;
            scan_phase  = PH_LEB;
          end
          C_TABLE: begin
            count_acc   = '0;
            count_shift = '0;
            scan_phase  = PH_COUNT;
          end
          C_FIX1: begin
            fixed_left = FIXED_BITS'(1);
            scan_phase = PH_FIXED;
          end
          C_FIX4: begin
            fixed_left = FIXED_BITS'(4);
            scan_phase = PH_FIXED;
          end
          C_FIX8: begin
            fixed_left = FIXED_BITS'(8);
            scan_phase = PH_FIXED;
          end
          default: ;
        endcase
      end
      PH_LEB: begin
        if (!code[7]) begin
          if (lebs_left != '0) lebs_left--;
          if (lebs_left == '0) begin
            if (fixed_after) begin
              fixed_after = 1'b0;
              fixed_left  = FIXED_BITS'(1);
              scan_phase  = PH_FIXED;
            end else begin
              scan_phase = PH_OPCODE;
            end
          end
        end
      end
      PH_FIXED: begin
        if (fixed_left != '0) fixed_left--;
        if (fixed_left == '0) scan_phase = PH_OPCODE;
      end
      PH_COUNT: begin
        // count bits past 32 fall off the top
        if (count_shift < SHIFT_BITS'(5)) begin
          count_acc = count_acc | (ACC_BITS'(code[6:0]) << (7 * count_shift));
          count_shift++;
        end
        if (!code[7]) begin
          lebs_left  = {1'b0, count_acc} + LEBS_BITS'(1);
          scan_phase = PH_LEB;
        end
      end
      default: scan_phase = PH_OPCODE;
    endcase
    if (hit || last) begin
      c.kind   = hit ? hit_kind : OUT_NOT_FOUND;
      c.offset = hit ? scan_offset : '0;
      pending_closes.push_back(c);
      closes_predicted++;
      scan_done = 1'b1;
    end
    if (scan_offset != OFFSET_MAX) scan_offset++;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: long hold-off on request, random short stalls otherwise
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 6) == 0) rx_stall_left = $urandom_range(1, 5);
      end
    end
  end

  // result checker and no-progress watchdog
  always @(posedge clk) begin : check_results
    close_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_closes.size() == 0) begin
          $error("unexpected result transfer: outcome %0d match_offset %0d",
                 out_tuser, out_tdata[OFFSET_BITS-1:0]);
          err_count++;
        end else begin
          want = pending_closes.pop_front();
          if (out_tuser != want.kind) begin
            $error("outcome: expected %0d, got %0d", want.kind, out_tuser);
            err_count++;
          end
          if (out_tdata[OFFSET_BITS-1:0] != want.offset) begin
            $error("match_offset: expected %0d, got %0d", want.offset,
                   out_tdata[OFFSET_BITS-1:0]);
            err_count++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("wasm_block_end_scanner_tb: errors");
        $finish;
      end
    end
  end

  // one byte transfer, with an optional random gap in front of it
  task automatic send_byte(input logic [7:0] code, input bit first, input bit last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_scan(code, first, last);
  endtask

  // a whole scan: first byte restarts, last byte optionally marks end of code
  task automatic send_scan(input logic [7:0] bytes[$], input bit mark_last);
    int i;
    for (i = 0; i < bytes.size(); i++)
      send_byte(bytes[i], i == 0, mark_last && i == bytes.size() - 1);
  endtask

  // stop sending and let every outstanding result drain out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_closes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDE_GET: wide_get_op = value;
      CFG_WIDE_SET: wide_set_op = value;
      default:      ;  // drop and select opcodes take no immediate either way
    endcase
  endtask

  task automatic test_directed_scans();
    logic [7:0] bytes[$];
    // idle after reset: bytes without first_byte are dropped, even one marked last
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(OP_UNREACHABLE, 1'b0, 1'b1);
    // end as the very first byte
    bytes = '{OP_END};
    send_scan(bytes, 1'b0);
    // two-byte block type, long LEB, memarg holding an else byte, then else at depth zero
    bytes = '{OP_BLOCK, 8'hC0, 8'h00, OP_I32_CONST, 8'h80, 8'h80, 8'h01,
              OP_I32_LOAD, 8'h82, 8'h01, 8'h05, OP_END, OP_ELSE};
    send_scan(bytes, 1'b0);
    // branch table with an oversized count encoding (bits past 32 and past 5 bytes dropped),
    // fixed fields, indirect call, nested if/else; closing end is also the last byte
    bytes = '{OP_BR_TBL, 8'h81, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h00, 8'h05, 8'h0B,
              OP_F32_CONST, 8'h0B, 8'h0B, 8'h0B, 8'h0B, OP_REF_NULL, 8'h70,
              OP_CALL_IND, 8'h0B, 8'h05, OP_IF, BT_EMPTY, OP_ELSE, OP_END, OP_END};
    send_scan(bytes, 1'b1);
    // restart in the middle of a block type immediate
    bytes = '{OP_LOOP};
    send_scan(bytes, 1'b0);
    bytes = '{OP_ELSE};
    send_scan(bytes, 1'b0);
    // code ends inside an 8-byte immediate: not found
    bytes = '{OP_F64_CONST, 8'h00, 8'hFF, 8'h7F};
    send_scan(bytes, 1'b1);
    // single-LEB opcodes, then end on the last byte
    bytes = '{OP_CALL, 8'hFF, 8'h0B, OP_REF_FUNC, 8'h05, OP_NOP, OP_END};
    send_scan(bytes, 1'b1);
    settle();
  endtask

  task automatic test_opcode_registers();
    logic [7:0] bytes[$];
    // extremes: 0x00 and 0xFF become one-LEB opcodes
    write_reg(CFG_WIDE_DROP, 8'h00);
    write_reg(CFG_WIDE_SELECT, 8'hFF);
    write_reg(CFG_WIDE_GET, 8'h00);
    write_reg(CFG_WIDE_SET, 8'hFF);
    bytes = '{8'h00, OP_ELSE, 8'hFF, OP_END, OP_ELSE};
    send_scan(bytes, 1'b0);
    // clash with standard opcodes: standard meaning wins
    write_reg(CFG_WIDE_DROP, 8'hFF);
    write_reg(CFG_WIDE_SELECT, 8'h00);
    write_reg(CFG_WIDE_GET, OP_END);
    write_reg(CFG_WIDE_SET, OP_I32_CONST);
    bytes = '{OP_END};
    send_scan(bytes, 1'b0);
    bytes = '{WIDE_SET_RESET, OP_END};
    send_scan(bytes, 1'b1);
    // back to the reset values
    write_reg(CFG_WIDE_DROP, 8'd200);
    write_reg(CFG_WIDE_SELECT, 8'd201);
    write_reg(CFG_WIDE_GET, WIDE_GET_RESET);
    write_reg(CFG_WIDE_SET, WIDE_SET_RESET);
    bytes = '{WIDE_GET_RESET, OP_END, WIDE_SET_RESET, OP_ELSE, OP_END};
    send_scan(bytes, 1'b0);
    settle();
  endtask

  // receiver holds off while single-byte scans keep coming, so the input stalls
  task automatic test_backpressure();
    logic [7:0] bytes[$];
    bytes = '{OP_END};
    rx_hold_cycles = HOLD_CYCLES;
    repeat (12) send_scan(bytes, 1'($urandom_range(0, 1)));
    settle();
  endtask

  // nest deep, unwind every level, then else closes at depth zero
  task automatic test_deep_nesting();
    send_byte(OP_BLOCK, 1'b1, 1'b0);
    send_byte(BT_EMPTY, 1'b0, 1'b0);
    repeat (NEST_LEVELS - 1) begin
      send_byte(OP_LOOP, 1'b0, 1'b0);
      send_byte(BT_EMPTY, 1'b0, 1'b0);
    end
    repeat (NEST_LEVELS) send_byte(OP_END, 1'b0, 1'b0);
    send_byte(OP_ELSE, 1'b0, 1'b0);
    settle();
  endtask

  function automatic void add_leb(ref logic [7:0] body[$]);
    int extra;
    extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : $urandom_range(0, 1);
    repeat (extra) body.push_back(LEB_MORE | 8'($urandom_range(0, 127)));
    body.push_back(8'($urandom_range(0, 127)));
  endfunction

  // one well-formed instruction with random immediates
  function automatic void add_instr(ref logic [7:0] body[$], ref int depth);
    logic [7:0] op;
    int         count;
    case ($urandom_range(0, 11))
      0: begin
        do op = 8'($urandom); while (effective_kind(op) != C_NONE);
        body.push_back(op);
      end
      1: begin
        if (depth < 5) begin
          body.push_back(8'($urandom_range(OP_BLOCK, OP_IF)));
          case ($urandom_range(0, 2))
            0:       body.push_back(BT_EMPTY);
            1:       body.push_back(8'($urandom_range(BT_FIRST_VAL, BT_LAST_VAL)));
            default: add_leb(body);
          endcase
          depth++;
        end
      end
      2: begin
        if (depth > 0) begin
          body.push_back(OP_END);
          depth--;
        end
      end
      3: if (depth > 0) body.push_back(OP_ELSE);
      4: begin
        do op = 8'($urandom); while (effective_kind(op) != C_LEB1);
        body.push_back(op);
        add_leb(body);
      end
      5: begin
        body.push_back(8'($urandom_range(OP_I32_LOAD, OP_I64_STORE32)));
        add_leb(body);
        add_leb(body);
      end
      6: begin
        count = $urandom_range(0, 3);
        body.push_back(OP_BR_TBL);
        if ($urandom_range(0, 3) == 0) begin
          // padded count encoding
          body.push_back(LEB_MORE | 8'(count));
          repeat ($urandom_range(0, 5)) body.push_back(LEB_MORE);
          body.push_back(8'h00);
        end else begin
          body.push_back(8'(count));
        end
        repeat (count + 1) add_leb(body);
      end
      7: begin
        body.push_back(OP_CALL_IND);
        add_leb(body);
        body.push_back(8'($urandom));
      end
      8: begin
        body.push_back(OP_F32_CONST);
        repeat (4) body.push_back(8'($urandom));
      end
      9: begin
        body.push_back(OP_F64_CONST);
        repeat (8) body.push_back(8'($urandom));
      end
      10: begin
        body.push_back(OP_REF_NULL);
        body.push_back(8'($urandom));
      end
      default: begin
        op = $urandom_range(0, 1) ? wide_get_op : wide_set_op;
        if (opcode_kind(op) == C_NONE) begin
          body.push_back(op);
          add_leb(body);
        end
      end
    endcase
  endfunction

  // mostly well-formed scans; some raw noise, some cut short or restarted
  task automatic random_scan();
    logic [7:0] body[$];
    int         depth;
    int         cut;
    depth = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 10)) add_instr(body, depth);
      while (depth > 0) begin
        body.push_back(OP_END);
        depth--;
      end
      body.push_back($urandom_range(0, 1) ? OP_ELSE : OP_END);
    end
    if ($urandom_range(0, 7) == 0 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    send_scan(body, $urandom_range(0, 3) == 0);
    // trailing bytes, dropped once the scan has closed
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic test_random_streams();
    int phase;
    int live_start;
    int close_start;
    for (phase = 0; phase < 3; phase++) begin
      // last phase runs with no idling on either side
      if (phase == 2) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      write_reg(CFG_WIDE_DROP, 8'($urandom));
      write_reg(CFG_WIDE_SELECT, 8'($urandom));
      write_reg(CFG_WIDE_GET, 8'($urandom));
      write_reg(CFG_WIDE_SET, 8'($urandom));
      live_start  = live_bytes;
      close_start = closes_predicted;
      while (live_bytes - live_start < RANDOM_ITEMS / 3 ||
             closes_predicted - close_start < 15)
        random_scan();
      settle();
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_scans();
    test_opcode_registers();
    test_backpressure();
    test_deep_nesting();
    test_random_streams();

    // everything has drained; give a few more cycles for any stray result
    settle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("wasm_block_end_scanner_tb: clean");
    end else begin
      $display("wasm_block_end_scanner_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wbs_pkg.sv
src/wasm_block_end_scanner.sv
test/wasm_block_end_scanner_tb.sv
